@@ src/matrix3_inverse_determinant_unit_macros.svh @@
// Assertion macros for the 3x3 inverse unit.
`ifndef MATRIX3_INVERSE_DETERMINANT_UNIT_MACROS_SVH
`define MATRIX3_INVERSE_DETERMINANT_UNIT_MACROS_SVH

// Property must hold at every edge out of reset.
`define M3I_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true out of reset.
`define M3I_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

@@ src/m3i_pkg.sv @@
// Types and constants shared by the 3x3 inverse unit.
package m3i_pkg;

  localparam int unsigned NumLanes    = 9;
  localparam int unsigned DataW       = 24;
  localparam int unsigned DetW        = 40;
  localparam int unsigned ProdW       = 48;
  localparam int unsigned CofW        = 49;
  localparam int unsigned CofMagW     = 49;
  localparam int unsigned DetFullW    = 74;
  localparam int unsigned DetMagW     = 73;
  localparam int unsigned NumFracW    = 32;
  localparam int unsigned NumW        = CofMagW + NumFracW;
  localparam int unsigned QW          = 24;
  localparam int unsigned CmpW        = DetMagW + QW;
  // exact determinant carries 48 fraction bits; Q24.16 keeps 16 of them
  localparam int unsigned DetShift    = 32;
  localparam int unsigned DetShW      = DetMagW - DetShift;
  localparam int unsigned HiSplit     = 25;
  localparam int unsigned FrontStages = 5;
  localparam int unsigned DivStages   = QW + 1;
  localparam int unsigned NumStages   = FrontStages + DivStages + 1;

  localparam logic [QW-1:0] QPosLim = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] QNegLim = {1'b1, {(QW-1){1'b0}}};

  // cofactor k = m[PosA]*m[PosB] - m[NegA]*m[NegB], entries row major
  localparam int unsigned PosA [NumLanes] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned PosB [NumLanes] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned NegA [NumLanes] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned NegB [NumLanes] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic signed [DataW-1:0] m11;
    logic signed [DataW-1:0] m12;
    logic signed [DataW-1:0] m13;
    logic signed [DataW-1:0] m21;
    logic signed [DataW-1:0] m22;
    logic signed [DataW-1:0] m23;
    logic signed [DataW-1:0] m31;
    logic signed [DataW-1:0] m32;
    logic signed [DataW-1:0] m33;
  } mat_t;

  typedef struct packed {
    logic signed [DataW-1:0] inv11;
    logic signed [DataW-1:0] inv12;
    logic signed [DataW-1:0] inv13;
    logic signed [DataW-1:0] inv21;
    logic signed [DataW-1:0] inv22;
    logic signed [DataW-1:0] inv23;
    logic signed [DataW-1:0] inv31;
    logic signed [DataW-1:0] inv32;
    logic signed [DataW-1:0] inv33;
    logic signed [DetW-1:0]  det_value;
    logic                    singular;
    logic                    clipped;
  } res_t;

  // determinant info traveling beside the divider lanes
  typedef struct packed {
    logic [DetMagW-1:0] dmag;
    logic               dneg;
    logic               dzero;
    logic [DetW-1:0]    det_value;
    logic               det_clip;
  } side_t;

endpackage

@@ src/m3i_stream_if.sv @@
// Valid/ready stream interfaces for matrix beats and result beats.
interface m3i_in_if;
  import m3i_pkg::*;
  logic valid;
  logic ready;
  mat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface m3i_out_if;
  import m3i_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/m3i_front.sv @@
// Front pipeline: products, cofactors and determinant with saturation.
module m3i_front (
  input  logic                                clk_i,
  input  logic [m3i_pkg::FrontStages-1:0]     en_i,
  input  m3i_pkg::mat_t                       mat_i,
  output logic [m3i_pkg::CofMagW-1:0]         cmag_o [m3i_pkg::NumLanes],
  output logic                                cneg_o [m3i_pkg::NumLanes],
  output m3i_pkg::side_t                      side_o
);
  import m3i_pkg::*;

  logic signed [DataW-1:0]    m [NumLanes];
  logic signed [ProdW-1:0]    pp_q [NumLanes];
  logic signed [ProdW-1:0]    pn_q [NumLanes];
  logic signed [DataW-1:0]    mc0_q [3];
  logic signed [DataW-1:0]    mc1_q [3];
  logic signed [CofW-1:0]     c1_q [NumLanes];
  logic signed [CofW-1:0]     c2_q [NumLanes];
  logic signed [CofW-1:0]     c3_q [NumLanes];
  logic signed [DataW+HiSplit+1-1:0] lo_q [3];
  logic signed [ProdW-1:0]    hi_q [3];
  logic signed [DetFullW-1:0] det_q;
  logic signed [DetFullW-1:0] det_sum;
  logic signed [DetFullW-1:0] dabs;
  logic [DetShW-1:0]          dv;
  logic [DetShW-1:0]          dlim;
  logic [DetShW-1:0]          dsat;
  logic                       dclip;
  side_t                      side_d;

  assign m[0] = mat_i.m11;
  assign m[1] = mat_i.m12;
  assign m[2] = mat_i.m13;
  assign m[3] = mat_i.m21;
  assign m[4] = mat_i.m22;
  assign m[5] = mat_i.m23;
  assign m[6] = mat_i.m31;
  assign m[7] = mat_i.m32;
  assign m[8] = mat_i.m33;

  // stage 0: the eighteen 24x24 products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < NumLanes; k++) begin
        pp_q[k] <= m[PosA[k]] * m[PosB[k]];
        pn_q[k] <= m[NegA[k]] * m[NegB[k]];
      end
      for (int i = 0; i < 3; i++) begin
        mc0_q[i] <= m[3*i];
      end
    end
  end

  // stage 1: cofactors
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int k = 0; k < NumLanes; k++) begin
        c1_q[k] <= CofW'(pp_q[k]) - CofW'(pn_q[k]);
      end
      mc1_q <= mc0_q;
    end
  end

  // stage 2: first-column times cofactor, split in two partial products
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= mc1_q[i] * $signed({1'b0, c1_q[i][HiSplit-1:0]});
        hi_q[i] <= mc1_q[i] * $signed(c1_q[i][CofW-1:HiSplit]);
      end
      c2_q <= c1_q;
    end
  end

  always_comb begin
    det_sum = '0;
    for (int i = 0; i < 3; i++) begin
      det_sum = det_sum + (DetFullW'(hi_q[i]) <<< HiSplit) + DetFullW'(lo_q[i]);
    end
  end

  // stage 3: exact determinant
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      det_q <= det_sum;
      c3_q  <= c2_q;
    end
  end

  always_comb begin
    dabs          = det_q[DetFullW-1] ? -det_q : det_q;
    side_d.dneg   = det_q[DetFullW-1];
    side_d.dzero  = (det_q == '0);
    side_d.dmag   = dabs[DetMagW-1:0];
    dv            = side_d.dmag[DetMagW-1:DetShift];
    dlim          = side_d.dneg ? (DetShW'(1) << (DetW-1)) : ((DetShW'(1) << (DetW-1)) - 1'b1);
    dclip         = dv > dlim;
    dsat          = dclip ? dlim : dv;
    side_d.det_clip  = dclip;
    side_d.det_value = side_d.dneg ? -dsat[DetW-1:0] : dsat[DetW-1:0];
  end

  // stage 4: magnitudes and signs
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      for (int k = 0; k < NumLanes; k++) begin
        cmag_o[k] <= c3_q[k][CofW-1] ? CofMagW'(-c3_q[k]) : CofMagW'(c3_q[k]);
        cneg_o[k] <= c3_q[k][CofW-1];
      end
      side_o <= side_d;
    end
  end

endmodule

@@ src/m3i_div_lane.sv @@
// One divider lane: cofactor over determinant, one quotient bit a stage.
module m3i_div_lane (
  input  logic                              clk_i,
  input  logic [m3i_pkg::DivStages-1:0]     en_i,
  input  logic [m3i_pkg::CofMagW-1:0]       cmag_i,
  input  logic                              qneg_i,
  input  logic [m3i_pkg::DetMagW-1:0]       dmag_i [m3i_pkg::DivStages],
  output logic [m3i_pkg::QW-1:0]            q_o,
  output logic                              ovf_o,
  output logic                              qneg_o
);
  import m3i_pkg::*;

  logic [NumW-1:0] r_q   [DivStages-1];
  logic [QW-1:0]   q_q   [DivStages];
  logic            ovf_q [DivStages];
  logic            neg_q [DivStages];
  logic [NumW-1:0] num;

  assign num = {cmag_i, NumFracW'(0)};

  // quotient of 2^24 or more always saturates
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0]   <= num;
      q_q[0]   <= '0;
      ovf_q[0] <= CmpW'(num) >= {dmag_i[0], QW'(0)};
      neg_q[0] <= qneg_i;
    end
  end

  for (genvar j = 1; j < DivStages; j++) begin : g_step
    localparam int unsigned K = DivStages - 1 - j;
    logic [CmpW-1:0] shd;
    logic [CmpW-1:0] diff;
    logic            ge;

    assign shd  = CmpW'(dmag_i[j]) << K;
    assign ge   = CmpW'(r_q[j-1]) >= shd;
    assign diff = CmpW'(r_q[j-1]) - shd;

    if (j < DivStages - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          r_q[j] <= ge ? diff[NumW-1:0] : r_q[j-1];
        end
      end
    end

    // bit K is still clear in the incoming partial quotient
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        q_q[j]    <= q_q[j-1] | (QW'(ge) << K);
        ovf_q[j]  <= ovf_q[j-1];
        neg_q[j]  <= neg_q[j-1];
      end
    end
  end

  assign q_o    = q_q[DivStages-1];
  assign ovf_o  = ovf_q[DivStages-1];
  assign qneg_o = neg_q[DivStages-1];

endmodule

@@ src/matrix3_inverse_determinant_unit.sv @@
// Top level of the 3x3 fixed-point matrix inverse and determinant unit.
// Takes one Q8.16 3x3 matrix per beat and returns its inverse (Q8.16, truncated toward
// zero, saturated), its determinant (Q24.16, saturated) and singular/clipped flags.
// Throughput is one matrix per clock while the output is not stalled. The pipeline is
// the 5-stage product/cofactor/determinant front end, the 25-stage quotient pipeline
// (an overflow check, then one quotient bit per stage) and the merge register. Nine
// divider lanes run side by side, one per inverse entry; a merge stage saturates each
// quotient, ORs the clip flags and forces an all-zero result for a singular matrix.
// Every stage has its own valid bit and stalls only when it is full and the next stage
// cannot load, so beats keep entering while a result waits, until every stage is full.
module matrix3_inverse_determinant_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  m3i_in_if.sink       in_i,
  m3i_out_if.source    out_o
);
  import m3i_pkg::*;

  logic [NumStages-1:0] en;
  logic [NumStages-1:0] v_q;

  logic [CofMagW-1:0] cmag [NumLanes];
  logic               cneg [NumLanes];
  side_t              side0;
  side_t              sd_q [DivStages];
  logic [DetMagW-1:0] dvs  [DivStages];

  logic [QW-1:0]    q    [NumLanes];
  logic             ovf  [NumLanes];
  logic             qn   [NumLanes];
  logic [DataW-1:0] val  [NumLanes];
  logic             clip_any;
  side_t            sd_last;
  res_t             res_d;
  res_t             res_q;

  // stall chain: a stage may load when empty or when its successor loads
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_i.ready = en[0];

  m3i_front u_front (
    .clk_i  (clk_i),
    .en_i   (en[FrontStages-1:0]),
    .mat_i  (in_i.data),
    .cmag_o (cmag),
    .cneg_o (cneg),
    .side_o (side0)
  );

  // determinant info rides alongside the lanes; divisor aligned per stage
  always_ff @(posedge clk_i) begin
    if (en[FrontStages]) sd_q[0] <= side0;
    for (int j = 1; j < DivStages; j++) begin
      if (en[FrontStages+j]) sd_q[j] <= sd_q[j-1];
    end
  end

  always_comb begin
    dvs[0] = side0.dmag;
    for (int j = 1; j < DivStages; j++) begin
      dvs[j] = sd_q[j-1].dmag;
    end
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    m3i_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en[FrontStages +: DivStages]),
      .cmag_i (cmag[i]),
      .qneg_i (cneg[i] ^ side0.dneg),
      .dmag_i (dvs),
      .q_o    (q[i]),
      .ovf_o  (ovf[i]),
      .qneg_o (qn[i])
    );
  end

  assign sd_last = sd_q[DivStages-1];

  // merge: saturate each lane, gather clip flags, zero a singular result
  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    logic          sat;
    clip_any = sd_last.det_clip;
    for (int i = 0; i < NumLanes; i++) begin
      lim      = qn[i] ? QNegLim : QPosLim;
      sat      = ovf[i] || (q[i] > lim);
      mag      = sat ? lim : q[i];
      val[i]   = qn[i] ? -mag : mag;
      clip_any = clip_any | sat;
    end
    res_d.inv11     = val[0];
    res_d.inv12     = val[1];
    res_d.inv13     = val[2];
    res_d.inv21     = val[3];
    res_d.inv22     = val[4];
    res_d.inv23     = val[5];
    res_d.inv31     = val[6];
    res_d.inv32     = val[7];
    res_d.inv33     = val[8];
    res_d.det_value = sd_last.det_value;
    res_d.singular  = 1'b0;
    res_d.clipped   = clip_any;
    if (sd_last.dzero) begin
      res_d          = '0;
      res_d.singular = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) res_q <= res_d;
  end

  assign out_o.valid = v_q[NumStages-1];
  assign out_o.data  = res_q;

endmodule

@@ src/m3i_checker.sv @@
// Port-level checks for the 3x3 inverse unit, bound to the top level.
`include "matrix3_inverse_determinant_unit_macros.svh"

module m3i_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input m3i_pkg::res_t out_data_i
);
  import m3i_pkg::*;

  logic [5:0] cnt_q;
  logic [5:0] cnt_d;
  logic       inv_zero;

  always_comb begin
    cnt_d = cnt_q + 6'(in_valid_i && in_ready_i) - 6'(out_valid_i && out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign inv_zero = (out_data_i.inv11 == '0) && (out_data_i.inv12 == '0) &&
                    (out_data_i.inv13 == '0) && (out_data_i.inv21 == '0) &&
                    (out_data_i.inv22 == '0) && (out_data_i.inv23 == '0) &&
                    (out_data_i.inv31 == '0) && (out_data_i.inv32 == '0) &&
                    (out_data_i.inv33 == '0) && (out_data_i.det_value == '0);

  `M3I_ASSERT(a_no_orphan, clk_i, rst_ni, out_valid_i |-> cnt_q != 6'd0, "result without input")
  `M3I_ASSERT_NEVER(a_capacity, clk_i, rst_ni, cnt_q > 6'(NumStages), "too many in flight")
  `M3I_ASSERT(a_singular, clk_i, rst_ni, out_valid_i && out_data_i.singular |-> inv_zero && !out_data_i.clipped, "singular not zeroed")
  `M3I_ASSERT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "stalled beat changed")

endmodule

bind matrix3_inverse_determinant_unit m3i_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

@@ test/m3i_inverse_checker.sv @@
// Checker for the 3x3 inverse unit: predicts each result and compares it.
`timescale 1ns / 1ps
module m3i_inverse_checker
  import m3i_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  mat_t in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  res_t out_data_i,
  output int   errors_o,
  output int   pending_o
);

  res_t inverse_q[$];

  function automatic res_t predict_inverse(mat_t mt);
    logic signed [DataW-1:0] m [9];
    logic signed [63:0]  c [9];
    logic signed [127:0] det;
    logic [127:0] dmag, num, q, lim;
    logic dneg, neg, clip;
    logic signed [23:0] e [9];
    logic signed [39:0] dv;
    res_t r;
    m = '{mt.m11, mt.m12, mt.m13, mt.m21, mt.m22, mt.m23, mt.m31, mt.m32, mt.m33};
    for (int k = 0; k < 9; k++) begin
      c[k] = 64'(m[PosA[k]]) * 64'(m[PosB[k]]) - 64'(m[NegA[k]]) * 64'(m[NegB[k]]);
    end
    det = 128'(m[0]) * 128'(c[0]) + 128'(m[3]) * 128'(c[1]) + 128'(m[6]) * 128'(c[2]);
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    clip = 1'b0;
    dneg = det < 0;
    dmag = dneg ? -det : det;
    for (int k = 0; k < 9; k++) begin
      num = (c[k] < 0 ? 128'(-c[k]) : 128'(c[k])) << 32;
      q = num / dmag;
      neg = (c[k] < 0) != dneg;
      lim = neg ? 128'(1) << 23 : (128'(1) << 23) - 1;
      if (q > lim) begin
        q = lim;
        clip = 1'b1;
      end
      e[k] = neg ? 24'(-q) : 24'(q);
    end
    q = dmag >> 32;
    lim = dneg ? 128'(1) << 39 : (128'(1) << 39) - 1;
    if (q > lim) begin
      q = lim;
      clip = 1'b1;
    end
    dv = dneg ? 40'(-q) : 40'(q);
    r = '{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], dv, 1'b0, clip};
    return r;
  endfunction

  assign pending_o = inverse_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) inverse_q.push_back(predict_inverse(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = inverse_q.pop_front();
          if (exp_r !== out_data_i) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_data_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ test/tb_matrix3_inverse_determinant_unit.sv @@
// Testbench top for the 3x3 inverse unit: stimulus, backpressure and verdict.
`timescale 1ns / 1ps
module tb_matrix3_inverse_determinant_unit;
  import m3i_pkg::*;

  logic clk_i, rst_ni;
  m3i_in_if  in_i ();
  m3i_out_if out_o ();
  int errors, pending, cycles;
  int src_idle, snk_idle;   // idle percentages
  logic hold_off;           // long receiver stall

  matrix3_inverse_determinant_unit dut (.clk_i, .rst_ni, .in_i(in_i.sink), .out_o(out_o.source));

  m3i_inverse_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_i(in_i.ready), .in_data_i(in_i.data),
    .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .out_data_i(out_o.data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout; pipeline latency plus stalls, generous margin.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 200000) begin
        $display("matrix3_inverse_determinant_unit test failed");
        $finish;
      end
    end
  end

  // Receiver: random ready at the falling edge, forced low during hold-off.
  initial begin
    out_o.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_o.ready <= !hold_off && ($urandom_range(99) >= snk_idle);
    end
  end

  function automatic logic [23:0] rand_entry();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(signed'($urandom_range(8)) - 4) <<< 16;  // small integers
      3: return 24'(signed'($urandom_range(64)) - 32);       // tiny fractions
      4: return 24'd0;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t mt;
    int k;
    mt = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
          rand_entry(), rand_entry(), rand_entry(), rand_entry()};
    k = $urandom_range(9);
    if (k == 0) mt.m21 = mt.m11;  // duplicate-ish rows often singular
    if (k == 1) begin
      mt.m21 = mt.m11; mt.m22 = mt.m12; mt.m23 = mt.m13;  // exactly singular
    end
    return mt;
  endfunction

  // valid stays up between beats unless the sender idles
  task automatic send_matrix(mat_t mt);
    while ($urandom_range(99) < src_idle) begin
      in_i.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_i.valid <= 1'b1;
    in_i.data  <= mt;
    do @(posedge clk_i); while (!in_i.ready);
    @(negedge clk_i);
  endtask

  localparam logic [23:0] One = 24'h010000;
  localparam logic [23:0] Max = 24'h7FFFFF;
  localparam logic [23:0] Min = 24'h800000;

  initial begin
    hold_off = 1'b0;
    src_idle = 35;
    snk_idle = 56;
    in_i.valid = 1'b0;
    in_i.data  = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity, zero, saturation, large determinant, negatives.
    send_matrix({One, 24'd0, 24'd0, 24'd0, One, 24'd0, 24'd0, 24'd0, One});
    send_matrix('0);
    send_matrix({Max, 24'd0, 24'd0, 24'd0, Max, 24'd0, 24'd0, 24'd0, Max});
    send_matrix({Min, 24'd0, 24'd0, 24'd0, Min, 24'd0, 24'd0, 24'd0, Min});
    send_matrix({24'd1, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd1});
    send_matrix({Max, Min, Max, Min, Max, Min, Max, Min, Max});
    send_matrix({Max, Max, Max, Max, Max, Max, Max, Max, Max});
    send_matrix({24'hFF0000, 24'd0, 24'd0, 24'd0, One, 24'd0, 24'd0, 24'd0, One});
    send_matrix({Min, Max, 24'd0, Max, Min, 24'd0, 24'd0, 24'd0, Min});
    send_matrix({24'hFFFFFF, 24'd1, 24'd0, 24'd3, Max, 24'd5, 24'd0, 24'd2, Min});

    for (int n = 0; n < 400; n++) begin
      if (n == 134) begin src_idle = 56; snk_idle = 35; end
      if (n == 267) begin src_idle = 0; snk_idle = 0; end
      if (n == 300) begin
        // Long receiver stall while matrices keep coming.
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      send_matrix(rand_matrix());
    end
    in_i.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("matrix3_inverse_determinant_unit test passed");
    end else begin
      $display("matrix3_inverse_determinant_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/m3i_pkg.sv
src/m3i_stream_if.sv
src/m3i_front.sv
src/m3i_div_lane.sv
src/matrix3_inverse_determinant_unit.sv
src/m3i_checker.sv
test/m3i_inverse_checker.sv
test/tb_matrix3_inverse_determinant_unit.sv
